// File: rtl/bdq_pkg.sv
// shared types and constants of the bounded deque
package bdq_pkg;

  // default sizing
  localparam int unsigned CapacityDef  = 16;
  localparam int unsigned DataWidthDef = 32;

  // fixed field widths of the transaction ports
  localparam int unsigned ValW = 32;
  localparam int unsigned OccW = 5;

  // requested operation
  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_e;

  // completion code of one transaction
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // input transaction
  typedef struct packed {
    action_e           action;
    logic signed [ValW-1:0] push_value;
  } item_t;

  // result transaction
  typedef struct packed {
    status_e                status;
    logic signed [ValW-1:0] popped_value;
    logic [OccW-1:0]        occupancy;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic refuse;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_pop;
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

// File: rtl/bdq_datapath.sv
// ring buffer storage, front pointer and fill count of the deque
module bdq_datapath import bdq_pkg::*; #(
  parameter int unsigned CAPACITY   = CapacityDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  item_t                  item_i,
  input  dp_cmd_t                cmd_i,
  output dp_stat_t               stat_o,
  output logic signed [ValW-1:0] popped_o,
  output logic [OccW-1:0]        occupancy_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [AW-1:0] LastIdx = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FullCnt = CW'(CAPACITY);
  localparam logic [SW-1:0] CapS    = SW'(CAPACITY);

  item_t                 item_q;
  logic [AW-1:0]         front_q, front_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  pop_q, pop_d;
  logic [DATA_WIDTH-1:0] rdata_q;
  logic [DATA_WIDTH-1:0] mem_q [CAPACITY];

  logic [AW-1:0]         front_dec, front_inc, back_idx, addr;
  logic [SW-1:0]         back_sum;
  logic signed [63:0]    push_wide, pop_wide;
  logic                  is_pop, is_front, do_op, wr_en, rd_en;

  // decode of the held transaction
  assign is_pop   = item_q.action[1];
  assign is_front = item_q.action inside {ACT_PUSH_FRONT, ACT_POP_FRONT};

  assign stat_o.is_pop = is_pop;
  assign stat_o.empty  = (count_q == '0);
  assign stat_o.full   = (count_q == FullCnt);

  // wrapped neighbors of the front pointer
  assign front_dec = (front_q == '0) ? LastIdx : front_q - AW'(1);
  assign front_inc = (front_q == LastIdx) ? '0 : front_q + AW'(1);

  // slot past the back on push, last slot on pop; sum stays below twice the capacity unless a pop meets an empty deque
  always_comb begin
    back_sum = SW'(front_q) + SW'(count_q) - (is_pop ? SW'(1) : SW'(0));
    if (back_sum >= CapS) begin
      back_sum = back_sum - CapS;
    end
    back_idx = back_sum[AW-1:0];
  end

  // memory address and enables
  assign do_op = cmd_i.exec && !cmd_i.refuse;
  assign wr_en = do_op && !is_pop;
  assign rd_en = do_op && is_pop;

  always_comb begin
    case (item_q.action)
      ACT_PUSH_FRONT: addr = front_dec;
      ACT_POP_FRONT:  addr = front_q;
      default:        addr = back_idx;
    endcase
  end

  // pointer and count updates
  always_comb begin
    front_d = front_q;
    count_d = count_q;
    pop_d   = pop_q;
    if (cmd_i.exec) begin
      pop_d = rd_en;
    end
    if (do_op) begin
      if (is_pop) begin
        count_d = count_q - CW'(1);
        if (is_front) begin
          front_d = front_inc;
        end
      end else begin
        count_d = count_q + CW'(1);
        if (is_front) begin
          front_d = front_dec;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      pop_q   <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      pop_q   <= pop_d;
    end
  end

  // transaction holding register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  // entry storage, one access per cycle, registered read
  assign push_wide = 64'(item_q.push_value);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr] <= push_wide[DATA_WIDTH-1:0];
    end
    if (rd_en) begin
      rdata_q <= mem_q[addr];
    end
  end

  // result fields
  assign pop_wide    = 64'($signed(rdata_q));
  assign popped_o    = pop_q ? pop_wide[ValW-1:0] : '0;
  assign occupancy_o = OccW'(count_q);

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("fill count above capacity");

  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q <= LastIdx)
    else $error("front pointer out of range");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(count_q) && $stable(front_q))
    else $error("pointers moved without an executed transaction");

endmodule

// File: rtl/bdq_ctrl.sv
// sequencing of one transaction and result strobe of the deque
module bdq_ctrl import bdq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     done_o,
  output status_e  status_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e  state_q;
  logic    done_q;
  status_e status_q;
  logic    refuse;

  // a pop into an empty deque or a push into a full one is refused
  assign refuse = stat_i.is_pop ? stat_i.empty : stat_i.full;

  assign busy         = (state_q == S_EXEC);
  assign cmd_o.load   = start && !busy;
  assign cmd_o.exec   = (state_q == S_EXEC);
  assign cmd_o.refuse = refuse;
  assign done_o       = done_q;
  assign status_o     = status_q;

  // state and registered result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      status_q <= ST_DONE;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          done_q  <= 1'b1;
          state_q <= S_RESP;
          if (!refuse) begin
            status_q <= ST_DONE;
          end else if (stat_i.is_pop) begin
            status_q <= ST_EMPTY;
          end else begin
            status_q <= ST_FULL;
          end
        end
        S_RESP: begin
          state_q <= start ? S_EXEC : S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_done_in_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_RESP)
    else $error("result strobe outside response state");

  a_exec_then_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> state_q == S_RESP && done_q)
    else $error("executed transaction gave no result");

  a_full_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC && !stat_i.is_pop |=> status_q != ST_EMPTY)
    else $error("empty status reported for a push");

endmodule

// File: rtl/bounded_deque.sv
// Bounded double-ended queue of signed values kept in a ring buffer.
// A transaction is taken when start is high and busy is low. Each transaction
// passes through the execution state, with busy high, during which the entry
// memory is written or read at the computed slot, the fill count moves and,
// for front operations, the front pointer; the result follows in the next cycle
// on result_o with done_o high for that single cycle, and the popped value comes
// straight from the memory's registered read port. A new transaction may be
// started during the result cycle, but not while busy is high in execution.
// The receiver cannot stall: done_o is a one-cycle strobe and must be taken.
// A pop from an empty deque reports empty status, a push into a full deque
// reports full status and drops the value; neither changes the contents.
// No clearing pass runs after reset: the deque is usable at once.
module bounded_deque import bdq_pkg::*; #(
  parameter int unsigned CAPACITY   = CapacityDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    done_o,
  output result_t result_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  status_e  status;

  // sequencing
  bdq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .done_o   (done_o),
    .status_o (status)
  );

  // storage and pointers
  bdq_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .popped_o    (result_o.popped_value),
    .occupancy_o (result_o.occupancy)
  );

  assign result_o.status = status;

endmodule
